FILE: src/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // Register widths and reset values
  localparam int unsigned CFG_BITS   = 31;
  localparam int unsigned LIMIT_BITS = 8;
  localparam int unsigned CIDX_BITS  = 2;

  localparam logic [CFG_BITS-1:0]   RETRY_FLOOR_RST  = 31'd8000;
  localparam logic [CFG_BITS-1:0]   BACKOFF_MAX_RST  = 31'd60000;
  localparam logic [CFG_BITS-1:0]   GRACE_WINDOW_RST = 31'd90000;
  localparam logic [LIMIT_BITS-1:0] MISS_LIMIT_RST   = 8'd3;

  // Register indexes
  localparam logic [CIDX_BITS-1:0] REG_RETRY_FLOOR  = 2'd0;
  localparam logic [CIDX_BITS-1:0] REG_BACKOFF_MAX  = 2'd1;
  localparam logic [CIDX_BITS-1:0] REG_GRACE_WINDOW = 2'd2;
  localparam logic [CIDX_BITS-1:0] REG_MISS_LIMIT   = 2'd3;

  // Radio mode codes
  localparam logic [1:0] RADIO_OFF     = 2'd0;
  localparam logic [1:0] RADIO_STATION = 2'd1;
  localparam logic [1:0] RADIO_HOTSPOT = 2'd2;
  localparam logic [1:0] RADIO_BOTH    = 2'd3;

  typedef enum logic [1:0] {
    EV_TICK     = 2'd0,
    EV_ACTIVITY = 2'd1,
    EV_ATTEMPT  = 2'd2,
    EV_RESTART  = 2'd3
  } lrs_mode_t;

  typedef enum logic [2:0] {
    ACT_IDLE      = 3'd0,
    ACT_DROP      = 3'd1,
    ACT_RECONNECT = 3'd2,
    ACT_DEFER     = 3'd3,
    ACT_JOIN      = 3'd4
  } lrs_action_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]   retry_floor;
    logic [CFG_BITS-1:0]   backoff_max;
    logic [CFG_BITS-1:0]   grace_window;
    logic [LIMIT_BITS-1:0] miss_limit;
  } lrs_cfg_t;

  typedef struct packed {
    lrs_mode_t   mode;
    logic [31:0] now_time;
    logic        auto_enable;
    logic        has_address;
    logic        link_up;
    logic [1:0]  radio_mode;
    logic [7:0]  client_count;
    logic        attempt_ok;
  } lrs_event_t;

  typedef struct packed {
    lrs_action_t action;
    logic        hotspot_busy;
    logic [1:0]  join_radio_mode;
    logic        restore_needed;
  } lrs_result_t;

endpackage

`default_nettype wire

FILE: src/lrs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lrs_pkg::CIDX_BITS-1:0] cfg_index,
  input  wire logic [lrs_pkg::CFG_BITS-1:0]  cfg_data,
  output lrs_pkg::lrs_cfg_t                  cfg
);
  import lrs_pkg::*;

  // Register file, one write per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_floor  <= RETRY_FLOOR_RST;
      cfg.backoff_max  <= BACKOFF_MAX_RST;
      cfg.grace_window <= GRACE_WINDOW_RST;
      cfg.miss_limit   <= MISS_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RETRY_FLOOR:  cfg.retry_floor  <= cfg_data;
        REG_BACKOFF_MAX:  cfg.backoff_max  <= cfg_data;
        REG_GRACE_WINDOW: cfg.grace_window <= cfg_data;
        REG_MISS_LIMIT:   cfg.miss_limit   <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/lrs_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_engine #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lrs_pkg::lrs_cfg_t   cfg,
  input  wire logic                advance,
  input  wire lrs_pkg::lrs_event_t ev,
  output lrs_pkg::lrs_result_t     res
);
  import lrs_pkg::*;

  // Wrap-safe compare: deadline reached when (now - deadline) is non-negative
  function automatic logic reached(input logic [TIME_BITS-1:0] now_t,
                                   input logic [TIME_BITS-1:0] dl);
    logic [TIME_BITS-1:0] diff;
    diff = now_t - dl;
    return ~diff[TIME_BITS-1];
  endfunction

  logic [CFG_BITS-1:0]   backoff_now, backoff_now_next;
  logic [TIME_BITS-1:0]  retry_deadline, retry_deadline_next;
  logic [LIMIT_BITS-1:0] miss_count, miss_count_next;
  logic [TIME_BITS-1:0]  activity_time, activity_time_next;
  logic                  activity_seen, activity_seen_next;

  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  grace_dl;
  logic                  busy;
  logic                  hotspot_up;
  logic [CFG_BITS:0]     dbl;
  logic [CFG_BITS-1:0]   dbl_sat;
  logic [CFG_BITS-1:0]   dl_addend;
  logic [TIME_BITS-1:0]  dl_sum;
  logic [LIMIT_BITS-1:0] miss_inc;
  lrs_action_t           action;

  assign now_t      = TIME_BITS'(ev.now_time);
  assign hotspot_up = (ev.radio_mode == RADIO_HOTSPOT) || (ev.radio_mode == RADIO_BOTH);

  // Activity state after this event
  always_comb begin
    activity_time_next = activity_time;
    activity_seen_next = activity_seen;
    unique case (ev.mode)
      EV_ACTIVITY: begin
        activity_time_next = now_t;
        activity_seen_next = 1'b1;
      end
      EV_RESTART: begin
        activity_time_next = '0;
        activity_seen_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Busy against the updated activity state
  assign grace_dl = activity_time_next + TIME_BITS'(cfg.grace_window);
  assign busy     = (ev.client_count != 8'd0) ||
                    (activity_seen_next && !reached(now_t, grace_dl));

  // Doubled backoff, saturated at the ceiling
  assign dbl     = {backoff_now, 1'b0};
  assign dbl_sat = (dbl > {1'b0, cfg.backoff_max}) ? cfg.backoff_max : dbl[CFG_BITS-1:0];

  // Retry deadline adder, shared by defer and attempt outcome
  assign dl_addend = (ev.mode == EV_ATTEMPT) ? backoff_now_next : cfg.retry_floor;
  assign dl_sum    = now_t + TIME_BITS'(dl_addend);
  assign miss_inc  = miss_count + 8'd1;

  // Backoff, miss count and action
  always_comb begin
    backoff_now_next = backoff_now;
    miss_count_next  = miss_count;
    action           = ACT_IDLE;
    unique case (ev.mode)
      EV_TICK: begin
        priority if (!ev.auto_enable) begin
          backoff_now_next = cfg.retry_floor;
          miss_count_next  = '0;
        end else if (ev.has_address) begin
          backoff_now_next = cfg.retry_floor;
          if (ev.link_up) begin
            miss_count_next = '0;
            if (hotspot_up && !busy) begin
              action = ACT_DROP;
            end
          end else if (miss_inc >= cfg.miss_limit) begin
            miss_count_next = '0;
            action          = ACT_RECONNECT;
          end else begin
            miss_count_next = miss_inc;
          end
        end else begin
          miss_count_next = '0;
          priority if (busy) begin
            action = ACT_DEFER;
          end else if (reached(now_t, retry_deadline)) begin
            action = ACT_JOIN;
          end else begin
            action = ACT_IDLE;
          end
        end
      end
      EV_ATTEMPT: begin
        backoff_now_next = ev.attempt_ok ? cfg.retry_floor : dbl_sat;
      end
      EV_RESTART: begin
        backoff_now_next = cfg.retry_floor;
        miss_count_next  = '0;
      end
      default: ;
    endcase
  end

  // Retry deadline
  always_comb begin
    retry_deadline_next = retry_deadline;
    unique case (ev.mode)
      EV_TICK: begin
        if (action == ACT_DEFER) begin
          retry_deadline_next = dl_sum;
        end
      end
      EV_ATTEMPT: retry_deadline_next = dl_sum;
      EV_RESTART: retry_deadline_next = now_t;
      default: ;
    endcase
  end

  // State registers, updated when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_now    <= RETRY_FLOOR_RST;
      retry_deadline <= '0;
      miss_count     <= '0;
      activity_time  <= '0;
      activity_seen  <= 1'b0;
    end else if (advance) begin
      backoff_now    <= backoff_now_next;
      retry_deadline <= retry_deadline_next;
      miss_count     <= miss_count_next;
      activity_time  <= activity_time_next;
      activity_seen  <= activity_seen_next;
    end
  end

  assign res.action          = action;
  assign res.hotspot_busy    = busy;
  assign res.join_radio_mode = hotspot_up ? RADIO_BOTH : RADIO_STATION;
  assign res.restore_needed  = ~hotspot_up;

`ifndef SYNTH
  // A failed attempt never leaves the backoff above the ceiling
  a_backoff_sat: assert property (@(posedge clk) disable iff (rst)
    advance && ev.mode == EV_ATTEMPT && !ev.attempt_ok
    |=> backoff_now <= $past(cfg.backoff_max))
    else $error("backoff above ceiling after failed attempt");

  // Restart clears activity tracking and miss count
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    advance && ev.mode == EV_RESTART
    |=> !activity_seen && miss_count == '0 && activity_time == '0)
    else $error("restart left state behind");

  // After a miss the count stays below the limit or has been cleared
  a_miss_bound: assert property (@(posedge clk) disable iff (rst)
    advance && ev.mode == EV_TICK && ev.auto_enable && ev.has_address && !ev.link_up
    |=> miss_count == '0 || miss_count < $past(cfg.miss_limit))
    else $error("miss count reached limit without reconnect");
`endif

endmodule

`default_nettype wire

FILE: src/link_retry_supervisor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// event     ev_valid / ev_stall  mode, now_time, auto_enable, has_address, link_up,
//                                radio_mode, client_count, attempt_ok
// result    res_valid/res_stall  action, hotspot_busy, join_radio_mode, restore_needed
// config    cfg_write            cfg_index, cfg_data
//
// One item per cycle sustained unless res_stall holds the result; an item passes
// through the input register, then the result register, before it shows on the
// result port.
// rst is synchronous: clears both valid flags, the supervisor state and the
// registers to their defaults.
// ev_stall rises only while both the input and the result register are full and
// res_stall holds the result.

module link_retry_supervisor_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // event channel
  input  wire logic                          ev_valid,
  output logic                               ev_stall,
  input  wire logic [1:0]                    mode,
  input  wire logic [31:0]                   now_time,
  input  wire logic                          auto_enable,
  input  wire logic                          has_address,
  input  wire logic                          link_up,
  input  wire logic [1:0]                    radio_mode,
  input  wire logic [7:0]                    client_count,
  input  wire logic                          attempt_ok,
  // result channel
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [2:0]                         action,
  output logic                               hotspot_busy,
  output logic [1:0]                         join_radio_mode,
  output logic                               restore_needed,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [lrs_pkg::CIDX_BITS-1:0] cfg_index,
  input  wire logic [lrs_pkg::CFG_BITS-1:0]  cfg_data
);
  import lrs_pkg::*;

  lrs_cfg_t    cfg;
  lrs_event_t  ev_in;
  lrs_event_t  ev_q;
  logic        ev_q_valid;
  logic        advance;
  logic        ev_take;
  lrs_result_t res_d;
  lrs_result_t res_q;

  lrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the item moves on when the result register is free or draining
  assign advance  = ev_q_valid && (!res_valid || !res_stall);
  assign ev_stall = ev_q_valid && !advance;
  assign ev_take  = ev_valid && !ev_stall;

  assign ev_in.mode         = lrs_mode_t'(mode);
  assign ev_in.now_time     = now_time;
  assign ev_in.auto_enable  = auto_enable;
  assign ev_in.has_address  = has_address;
  assign ev_in.link_up      = link_up;
  assign ev_in.radio_mode   = radio_mode;
  assign ev_in.client_count = client_count;
  assign ev_in.attempt_ok   = attempt_ok;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_q_valid <= 1'b0;
    end else if (ev_take) begin
      ev_q_valid <= 1'b1;
    end else if (advance) begin
      ev_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      ev_q <= ev_in;
    end
  end

  lrs_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .ev      (ev_q),
    .res     (res_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign action          = res_q.action;
  assign hotspot_busy    = res_q.hotspot_busy;
  assign join_radio_mode = res_q.join_radio_mode;
  assign restore_needed  = res_q.restore_needed;

`ifndef SYNTH
  // Input stalls only when a held result blocks the path
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    ev_stall |-> (ev_q_valid && res_valid && res_stall))
    else $error("event stalled with room downstream");

  // An item leaving the input register always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("item lost between registers");
`endif

endmodule

`default_nettype wire

FILE: test/link_retry_supervisor_core_tb.sv
`timescale 1ns / 1ps

module link_retry_supervisor_core_tb;
  import lrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned FLOOD_ITEMS = 40;

  // One row of the directed table
  typedef struct {
    lrs_event_t  ev;
    bit          typed;
    lrs_result_t res;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  // DUT drive and observe
  logic                  ev_valid  = 1'b0;
  lrs_event_t            ev_drv    = '0;
  logic                  res_stall = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CIDX_BITS-1:0]  cfg_index = REG_RETRY_FLOOR;
  logic [CFG_BITS-1:0]   cfg_data  = '0;
  logic                  ev_stall;
  logic                  res_valid;
  logic [2:0]            action;
  logic                  hotspot_busy;
  logic [1:0]            join_radio_mode;
  logic                  restore_needed;

  // Supervisor shadow: registers and state
  lrs_cfg_t              knobs;
  logic [31:0]           backoff_cur;
  logic [31:0]           retry_at;
  logic [7:0]            miss_run;
  logic [31:0]           act_stamp;
  logic                  act_seen;

  // Stimulus state
  logic [31:0]           wall_ms = '0;
  logic                  station_ip = 1'b0;
  logic                  station_link = 1'b0;
  stim_row_t             directed_rows[$];
  lrs_result_t           expected_results[$];
  lrs_result_t           oldest;

  // Bookkeeping
  int unsigned           cycle_count = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           results_checked = 0;
  int unsigned           act_hits[5] = '{default: 0};

  // Receiver stall pattern
  bit                    hold_start = 1'b0;
  int unsigned           hold_left = 0;
  int unsigned           style = 0;
  int unsigned           style_left = 0;
  logic [7:0]            stall_pat = '0;

  link_retry_supervisor_core uut (
    .clk             (clk),
    .rst             (rst),
    .ev_valid        (ev_valid),
    .ev_stall        (ev_stall),
    .mode            (ev_drv.mode),
    .now_time        (ev_drv.now_time),
    .auto_enable     (ev_drv.auto_enable),
    .has_address     (ev_drv.has_address),
    .link_up         (ev_drv.link_up),
    .radio_mode      (ev_drv.radio_mode),
    .client_count    (ev_drv.client_count),
    .attempt_ok      (ev_drv.attempt_ok),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .action          (action),
    .hotspot_busy    (hotspot_busy),
    .join_radio_mode (join_radio_mode),
    .restore_needed  (restore_needed),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wrap-safe: deadline reached when (now - deadline) has its sign bit clear
  function automatic bit deadline_passed(logic [31:0] now, logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return !diff[31];
  endfunction

  function automatic bit hotspot_in_use(logic [7:0] clients, logic [31:0] now);
    if (clients != 8'd0) return 1'b1;
    if (!act_seen) return 1'b0;
    return !deadline_passed(now, act_stamp + {1'b0, knobs.grace_window});
  endfunction

  // Predict one event and advance the shadow state
  function automatic lrs_result_t supervise_event(lrs_event_t ev);
    lrs_result_t r;
    logic [32:0] dbl;
    bit hs_up;
    hs_up = (ev.radio_mode == RADIO_HOTSPOT) || (ev.radio_mode == RADIO_BOTH);
    r.action = ACT_IDLE;
    case (ev.mode)
      EV_TICK: begin
        if (!ev.auto_enable) begin
          backoff_cur = {1'b0, knobs.retry_floor};
          miss_run = 8'd0;
        end else if (ev.has_address) begin
          backoff_cur = {1'b0, knobs.retry_floor};
          if (ev.link_up) begin
            miss_run = 8'd0;
            if (hs_up && !hotspot_in_use(ev.client_count, ev.now_time)) r.action = ACT_DROP;
          end else begin
            miss_run = miss_run + 8'd1;
            if (miss_run >= knobs.miss_limit) begin
              miss_run = 8'd0;
              r.action = ACT_RECONNECT;
            end
          end
        end else begin
          miss_run = 8'd0;
          if (hotspot_in_use(ev.client_count, ev.now_time)) begin
            retry_at = ev.now_time + {1'b0, knobs.retry_floor};
            r.action = ACT_DEFER;
          end else if (deadline_passed(ev.now_time, retry_at)) begin
            r.action = ACT_JOIN;
          end
        end
      end
      EV_ACTIVITY: begin
        act_stamp = ev.now_time;
        act_seen = 1'b1;
      end
      EV_ATTEMPT: begin
        if (ev.attempt_ok) begin
          backoff_cur = {1'b0, knobs.retry_floor};
        end else begin
          // double at full width, clamp to the ceiling
          dbl = {backoff_cur, 1'b0};
          if (dbl > {2'b00, knobs.backoff_max}) backoff_cur = {1'b0, knobs.backoff_max};
          else backoff_cur = dbl[31:0];
        end
        retry_at = ev.now_time + backoff_cur;
      end
      default: begin
        backoff_cur = {1'b0, knobs.retry_floor};
        retry_at = ev.now_time;
        miss_run = 8'd0;
        act_stamp = '0;
        act_seen = 1'b0;
      end
    endcase
    r.hotspot_busy = hotspot_in_use(ev.client_count, ev.now_time);
    r.join_radio_mode = hs_up ? RADIO_BOTH : RADIO_STATION;
    r.restore_needed = !hs_up;
    return r;
  endfunction

  // Random event: time mostly moves forward on the scale of the registers,
  // with jumps and hits right on the retry and grace deadlines
  function automatic lrs_event_t random_event();
    lrs_event_t ev;
    int unsigned roll;
    roll = $urandom_range(0, 11);
    case (roll)
      0:       wall_ms = $urandom();
      1, 2:    wall_ms = wall_ms + $urandom_range(0, 3);
      3, 4:    wall_ms = wall_ms + $urandom_range(0, {1'b0, knobs.retry_floor} + 32'd1);
      5, 6:    wall_ms = wall_ms + $urandom_range(0, {knobs.grace_window, 1'b1});
      7, 8:    wall_ms = wall_ms + $urandom_range(0, {knobs.backoff_max, 1'b1});
      9:       wall_ms = retry_at + $urandom_range(0, 2) - 32'd1;
      default: wall_ms = act_stamp + {1'b0, knobs.grace_window} + $urandom_range(0, 2) - 32'd1;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 52) ev.mode = EV_TICK;
    else if (roll < 64) ev.mode = EV_ACTIVITY;
    else if (roll < 94) ev.mode = EV_ATTEMPT;
    else ev.mode = EV_RESTART;
    // station status is sticky so miss runs can build up
    if ($urandom_range(0, 9) == 0) station_ip = ~station_ip;
    if ($urandom_range(0, 9) == 0) station_link = ~station_link;
    ev.now_time     = wall_ms;
    ev.auto_enable  = ($urandom_range(0, 9) != 0);
    ev.has_address  = ($urandom_range(0, 19) == 0) ? 1'($urandom()) : station_ip;
    ev.link_up      = ($urandom_range(0, 19) == 0) ? 1'($urandom()) : station_link;
    ev.radio_mode   = 2'($urandom_range(0, 3));
    ev.client_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    ev.attempt_ok   = ($urandom_range(0, 2) == 0);
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 30) $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one item, hold it until taken, then record its expected result
  task automatic offer_event(input lrs_event_t ev, input bit typed, input lrs_result_t typed_res);
    lrs_result_t pred;
    ev_drv = ev;
    ev_valid = 1'b1;
    do @(posedge clk); while (ev_stall);
    pred = supervise_event(ev);
    act_hits[pred.action]++;
    expected_results.push_back(typed ? typed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    ev_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop offering and wait until the block has nothing in flight
  task automatic drain();
    ev_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_knobs(input lrs_cfg_t k);
    cfg_write = 1'b1;
    cfg_index = REG_RETRY_FLOOR;
    cfg_data  = k.retry_floor;
    @(negedge clk);
    cfg_index = REG_BACKOFF_MAX;
    cfg_data  = k.backoff_max;
    @(negedge clk);
    cfg_index = REG_GRACE_WINDOW;
    cfg_data  = k.grace_window;
    @(negedge clk);
    // junk above the low byte must be ignored
    cfg_index = REG_MISS_LIMIT;
    cfg_data  = {23'($urandom()), k.miss_limit};
    @(negedge clk);
    cfg_write = 1'b0;
    knobs = k;
  endtask

  // Random bursts with random gaps
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned k;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < count; k++) begin
        offer_event(random_event(), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  task automatic add_row(input lrs_mode_t m, input logic [31:0] t, input logic [2:0] qual,
                         input logic [1:0] radio, input logic [7:0] clients, input logic ok);
    stim_row_t row;
    row.ev.mode         = m;
    row.ev.now_time     = t;
    row.ev.auto_enable  = qual[2];
    row.ev.has_address  = qual[1];
    row.ev.link_up      = qual[0];
    row.ev.radio_mode   = radio;
    row.ev.client_count = clients;
    row.ev.attempt_ok   = ok;
    row.typed           = 1'b0;
    row.res             = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input lrs_mode_t m, input logic [31:0] t, input logic [2:0] qual,
                           input logic [1:0] radio, input logic [7:0] clients, input logic ok,
                           input lrs_result_t res);
    add_row(m, t, qual, radio, clients, ok);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].res   = res;
  endtask

  // Receiver: random stall styles, each kept for a random run; long hold on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (style_left == 0) begin
      style = $urandom_range(0, 3);
      style_left = $urandom_range(8, 64);
      stall_pat = 8'($urandom());
    end
    style_left--;
    if (rst) begin
      res_stall = 1'b0;
    end else if (hold_left != 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      case (style)
        0:       res_stall = 1'b0;
        1:       res_stall = 1'($urandom());
        2:       res_stall = ($urandom_range(0, 3) == 0);
        default: res_stall = stall_pat[style_left % 8];
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        oldest = expected_results.pop_front();
        results_checked++;
        if (action !== oldest.action)
          report_mismatch($sformatf("action got %0d want %0d", action, oldest.action));
        if (hotspot_busy !== oldest.hotspot_busy)
          report_mismatch($sformatf("hotspot_busy got %0b want %0b",
                                    hotspot_busy, oldest.hotspot_busy));
        if (join_radio_mode !== oldest.join_radio_mode)
          report_mismatch($sformatf("join_radio_mode got %0d want %0d",
                                    join_radio_mode, oldest.join_radio_mode));
        if (restore_needed !== oldest.restore_needed)
          report_mismatch($sformatf("restore_needed got %0b want %0b",
                                    restore_needed, oldest.restore_needed));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    lrs_cfg_t knob_plan[PHASES];
    int unsigned ph;
    int unsigned i;

    // shadow reset
    knobs.retry_floor  = RETRY_FLOOR_RST;
    knobs.backoff_max  = BACKOFF_MAX_RST;
    knobs.grace_window = GRACE_WINDOW_RST;
    knobs.miss_limit   = MISS_LIMIT_RST;
    backoff_cur = {1'b0, RETRY_FLOOR_RST};
    retry_at    = '0;
    miss_run    = '0;
    act_stamp   = '0;
    act_seen    = 1'b0;

    // register settings per phase: defaults, tiny, zero, top, min over max, random, fully random
    knob_plan[0] = '{31'd8000, 31'd60000, 31'd90000, 8'd3};
    knob_plan[1] = '{31'd1, 31'd7, 31'd5, 8'd1};
    knob_plan[2] = '{31'd0, 31'd0, 31'd0, 8'd0};
    knob_plan[3] = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF};
    knob_plan[4] = '{31'd1000, 31'd300, 31'd2000, 8'd2};
    knob_plan[5] = '{31'($urandom_range(0, 50000)), 31'($urandom_range(0, 400000)),
                     31'($urandom_range(0, 200000)), 8'($urandom_range(1, 8))};
    knob_plan[6] = '{31'($urandom()), 31'($urandom()), 31'($urandom()), 8'($urandom())};

    // directed table, run under reset values of the registers
    add_typed(EV_TICK, 32'h0000_0000, 3'b000, RADIO_OFF, 8'd0, 1'b0,
              '{ACT_IDLE, 1'b0, RADIO_STATION, 1'b1});
    add_typed(EV_TICK, 32'hFFFF_FFFF, 3'b100, RADIO_BOTH, 8'd255, 1'b0,
              '{ACT_DEFER, 1'b1, RADIO_BOTH, 1'b0});
    add_row(EV_TICK, 32'd0, 3'b100, RADIO_STATION, 8'd0, 1'b0);      // wrapped deadline ahead
    add_row(EV_TICK, 32'd8000, 3'b100, RADIO_STATION, 8'd0, 1'b0);   // deadline met
    add_row(EV_ATTEMPT, 32'd100, 3'b000, RADIO_STATION, 8'd0, 1'b0);
    add_row(EV_ATTEMPT, 32'd200, 3'b000, RADIO_STATION, 8'd0, 1'b0);
    add_row(EV_ATTEMPT, 32'd300, 3'b000, RADIO_HOTSPOT, 8'd0, 1'b0); // hits the ceiling
    add_row(EV_ATTEMPT, 32'd400, 3'b111, RADIO_BOTH, 8'd0, 1'b0);
    add_row(EV_ATTEMPT, 32'd500, 3'b000, RADIO_OFF, 8'd0, 1'b1);     // success resets backoff
    add_row(EV_ACTIVITY, 32'd1000, 3'b000, RADIO_HOTSPOT, 8'd0, 1'b0);
    add_row(EV_TICK, 32'd50000, 3'b111, RADIO_HOTSPOT, 8'd0, 1'b0);  // inside grace
    add_row(EV_TICK, 32'd91000, 3'b111, RADIO_HOTSPOT, 8'd0, 1'b0);  // grace over: drop
    add_row(EV_TICK, 32'd92000, 3'b110, RADIO_BOTH, 8'd0, 1'b0);     // miss run
    add_row(EV_TICK, 32'd92010, 3'b110, RADIO_BOTH, 8'd0, 1'b0);
    add_row(EV_TICK, 32'd92020, 3'b110, RADIO_BOTH, 8'd0, 1'b0);
    add_row(EV_TICK, 32'd92100, 3'b100, RADIO_STATION, 8'd0, 1'b0);
    add_typed(EV_RESTART, 32'h8000_0000, 3'b000, RADIO_BOTH, 8'd0, 1'b1,
              '{ACT_IDLE, 1'b0, RADIO_BOTH, 1'b0});
    add_row(EV_TICK, 32'h8000_0000, 3'b100, RADIO_STATION, 8'd0, 1'b0);
    add_row(EV_ACTIVITY, 32'hFFFF_FF00, 3'b000, RADIO_OFF, 8'd0, 1'b0);
    add_row(EV_TICK, 32'h0000_0010, 3'b100, RADIO_STATION, 8'd0, 1'b0); // grace across wrap
    add_row(EV_TICK, 32'h0000_0020, 3'b000, RADIO_HOTSPOT, 8'd1, 1'b0);
    add_typed(EV_TICK, 32'hFFFF_FFFF, 3'b111, RADIO_BOTH, 8'hFF, 1'b1,
              '{ACT_IDLE, 1'b1, RADIO_BOTH, 1'b0});
    add_row(EV_ATTEMPT, 32'h7FFF_FFFF, 3'b111, RADIO_OFF, 8'hFF, 1'b0);

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].res);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      set_knobs(knob_plan[ph]);
      wall_ms = $urandom();
      if (ph == 0) begin
        // receiver holds off while the sender floods
        @(posedge clk);
        hold_start = 1'b1;
        @(negedge clk);
        for (i = 0; i < FLOOD_ITEMS; i++) offer_event(random_event(), 1'b0, '0);
      end
      run_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered %0d events over %0d register settings, %0d results checked, %0d mismatches",
             items_sent, PHASES, results_checked, mismatch_count);
    $display("Predicted actions: idle %0d, drop %0d, reconnect %0d, defer %0d, join %0d",
             act_hits[ACT_IDLE], act_hits[ACT_DROP], act_hits[ACT_RECONNECT],
             act_hits[ACT_DEFER], act_hits[ACT_JOIN]);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: link_retry_supervisor_core.f
src/lrs_pkg.sv
src/lrs_cfg_regs.sv
src/lrs_engine.sv
src/link_retry_supervisor_core.sv
test/link_retry_supervisor_core_tb.sv
